// File: hw/rtl/tkst_pkg.sv
// ---------------------------------------------------------------------------
// tkst_pkg
// Shared types and constants for the top-k score table.
// ---------------------------------------------------------------------------
package tkst_pkg;

  // Fixed field widths
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned RANK_W  = 7;
  localparam int unsigned TDATA_W = 40;  // rank + score, padded to whole bytes

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } tkst_state_t;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic ins;  // insert the offered score this cycle
    logic rot;  // rotate the chain one place towards cell 0
  } tkst_ctl_t;

endpackage

// File: hw/rtl/tkst_cell.sv
// ---------------------------------------------------------------------------
// tkst_cell
// One table position: holds a score, takes part in sorted insertion and
// hands its score to the neighbour above while the table is read out.
// ---------------------------------------------------------------------------
module tkst_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tkst_pkg::tkst_ctl_t               ctl,
  input  logic signed [tkst_pkg::SCORE_W-1:0] offer,
  input  logic signed [tkst_pkg::SCORE_W-1:0] up_score,   // cell above
  input  logic                              up_gt,      // offer beats cell above
  input  logic signed [tkst_pkg::SCORE_W-1:0] next_score, // cell below (wraps)
  output logic signed [tkst_pkg::SCORE_W-1:0] score,
  output logic                              gt          // offer beats this cell
);

  logic signed [tkst_pkg::SCORE_W-1:0] score_r;
  logic signed [tkst_pkg::SCORE_W-1:0] score_nxt;

  assign gt    = offer > score_r;
  assign score = score_r;

  // Insertion: a beaten cell takes the cell above's score, or the offer
  // itself when the cell above is not beaten
  always_comb begin
    score_nxt = score_r;
    if (ctl.ins && gt) begin
      score_nxt = up_gt ? up_score : offer;
    end else if (ctl.rot) begin
      score_nxt = next_score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else begin
      score_r <= score_nxt;
    end
  end

endmodule

// File: hw/rtl/tkst_ctrl.sv
// ---------------------------------------------------------------------------
// tkst_ctrl
// Sequencer: takes one offer, then walks the table out one beat per entry
// and works out the competition rank from the previous beat.
// ---------------------------------------------------------------------------
module tkst_ctrl #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic signed [tkst_pkg::SCORE_W-1:0] head_score,
  input  logic                                tail_gt,
  output logic [tkst_pkg::RANK_W-1:0]         rank,
  output logic                                accepted,
  output logic                                last,
  output tkst_pkg::tkst_ctl_t                 ctl
);

  localparam int unsigned CNT_W = $clog2(ENTRIES);

  tkst_pkg::tkst_state_t state_r, state_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic [tkst_pkg::RANK_W-1:0]   rank_r, rank_nxt;
  logic signed [tkst_pkg::SCORE_W-1:0] prev_r, prev_nxt;
  logic                          take_r, take_nxt;
  logic                          in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Rank: first position 1; a tie keeps the previous rank, else position+1
  always_comb begin
    if (pos_r == '0) begin
      rank = tkst_pkg::RANK_W'(1);
    end else if (head_score == prev_r) begin
      rank = rank_r;
    end else begin
      rank = tkst_pkg::RANK_W'(pos_r) + tkst_pkg::RANK_W'(1);
    end
  end

  assign accepted = take_r;
  assign last     = (pos_r == CNT_W'(ENTRIES - 1));

  // Next state and outputs
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    rank_nxt   = rank_r;
    prev_nxt   = prev_r;
    take_nxt   = take_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    ctl.ins    = 1'b0;
    ctl.rot    = 1'b0;
    case (state_r)
      tkst_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          ctl.ins   = 1'b1;
          take_nxt  = tail_gt;
          pos_nxt   = '0;
          state_nxt = tkst_pkg::ST_EMIT;
        end
      end
      tkst_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_fire) begin
          ctl.rot  = 1'b1;
          rank_nxt = rank;
          prev_nxt = head_score;
          if (last) begin
            pos_nxt   = '0;
            state_nxt = tkst_pkg::ST_IDLE;
          end else begin
            pos_nxt = pos_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = tkst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkst_pkg::ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    prev_r <= prev_nxt;
    take_r <= take_nxt;
  end

`ifndef SYNTHESIS
  a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");

  a_offer_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid && (pos_r == '0))
    else $error("readout did not start at the head");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && last |=> in_tready)
    else $error("not ready after last beat");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CNT_W'(ENTRIES - 1))
    else $error("position counter out of range");

  a_first_rank_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (pos_r == '0) |-> rank == tkst_pkg::RANK_W'(1))
    else $error("head beat rank is not one");
`endif

endmodule

// File: hw/rtl/top_k_score_table.sv
// ---------------------------------------------------------------------------
// top_k_score_table
// Keeps the ENTRIES best signed scores in descending order and, after each
// offer, streams the whole table out with competition ranks.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                      | tuser      | tlast
//  in_     | in  | [31:0] new_score           | -          | -
//  out_    | out | [6:0] rank, [38:7] score   | [0] accepted | last entry
//
//  With no back-pressure an offer is first inserted into the cell chain,
//  then the table goes out one beat per entry as the chain rotates one
//  place for each output beat taken.
//  Reset clears every cell to a zero score and returns the sequencer to idle.
//  A stalled output beat holds the chain still; no offer is taken until the
//  last beat of the previous table has gone.
// ---------------------------------------------------------------------------
module top_k_score_table #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [31:0] new_score
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tkst_pkg::TDATA_W-1:0] out_tdata,  // [6:0] rank, [38:7] score, pad
  output logic                         out_tuser,  // [0] accepted
  output logic                         out_tlast
);

  logic signed [tkst_pkg::SCORE_W-1:0] offer;
  logic signed [tkst_pkg::SCORE_W-1:0] scores [ENTRIES];
  logic                                gts    [ENTRIES];
  tkst_pkg::tkst_ctl_t                 ctl;
  logic [tkst_pkg::RANK_W-1:0]         rank;
  logic                                accepted;
  logic                                last;

  assign offer = $signed(in_tdata);

  // Cell chain, position 0 holds the best score
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic signed [tkst_pkg::SCORE_W-1:0] up_score;
    logic                                up_gt;
    if (i == 0) begin : g_head
      assign up_score = '0;
      assign up_gt    = 1'b0;
    end else begin : g_body
      assign up_score = scores[i-1];
      assign up_gt    = gts[i-1];
    end
    tkst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .offer      (offer),
      .up_score   (up_score),
      .up_gt      (up_gt),
      .next_score (scores[(i + 1) % ENTRIES]),
      .score      (scores[i]),
      .gt         (gts[i])
    );
  end

  // Sequencer and rank
  tkst_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head_score (scores[0]),
    .tail_gt    (gts[ENTRIES-1]),
    .rank       (rank),
    .accepted   (accepted),
    .last       (last),
    .ctl        (ctl)
  );

  // Output beat
  assign out_tdata = {1'b0, scores[0], rank};
  assign out_tuser = accepted;
  assign out_tlast = last;

`ifndef SYNTHESIS
  a_table_sorted_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> scores[0] >= scores[ENTRIES-1])
    else $error("table out of order while idle");
`endif

endmodule

// File: dv/tb_top_k_score_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top_k_score_table
// Self-checking bench for the top-k score table. A predictor keeps its own
// copy of the ranked scores and works out the ranked rows that each offer
// should produce. Every output beat is checked field by field against the
// oldest row still owed. Both stream sides idle at random. The receiver
// also holds off for a long stretch so that the input backs up.
// ---------------------------------------------------------------------------
module tb_top_k_score_table;

  localparam int unsigned N         = 8;
  localparam int unsigned IDLE_PCT  = 12;
  localparam int unsigned HOLD_CYC  = 150;
  localparam int unsigned QUIET_MAX = 2000;

  localparam logic signed [31:0] SCORE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SCORE_MIN = 32'sh80000000;

  // Opening offers: rejects at reset, ties, extremes, equal-to-lowest cases
  localparam logic signed [31:0] OPENING [17] = '{
    32'sd0, SCORE_MIN, -32'sd1, 32'sd1, 32'sd1, 32'sd3, 32'sd2, SCORE_MAX,
    32'sd1, 32'sd0, 32'sd4, 32'sd4, 32'sd4, 32'sd1, 32'sd2, SCORE_MAX,
    32'sh40000000
  };

  // One ranked row of the table as it leaves the block
  typedef struct {
    logic [tkst_pkg::RANK_W-1:0]         rank;
    logic signed [tkst_pkg::SCORE_W-1:0] score;
    logic                                accepted;
    logic                                last;
  } row_t;

  // Ranked-score predictor and the queue of rows still owed
  class ranking_board;
    logic signed [31:0] held [N];
    row_t               rows_due [$];
    int                 mismatches;

    function new();
      foreach (held[k]) held[k] = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    function logic signed [31:0] floor_score();
      return held[N-1];
    endfunction

    function logic signed [31:0] entry(int unsigned k);
      return held[k];
    endfunction

    // Offer accepted by the block: update the ranking, queue N rows
    function void take_offer(logic signed [31:0] s);
      row_t r;
      int   pos;
      int   above;
      bit   took;
      took = s > held[N-1];
      if (took) begin
        // new score sits below every entry that is >= it
        pos = 0;
        while (pos < N - 1 && held[pos] >= s) pos++;
        for (int k = N - 1; k > pos; k--) held[k] = held[k-1];
        held[pos] = s;
      end
      for (int k = 0; k < N; k++) begin
        above = 0;
        for (int j = 0; j < N; j++)
          if (held[j] > held[k]) above++;
        r.rank     = tkst_pkg::RANK_W'(above + 1);
        r.score    = held[k];
        r.accepted = took;
        r.last     = (k == N - 1);
        rows_due.push_back(r);
      end
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 'h%0h, got 'h%0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_row(logic [tkst_pkg::RANK_W-1:0] rank,
                            logic [tkst_pkg::SCORE_W-1:0] score,
                            logic accepted, logic last);
      row_t want;
      if (rows_due.size() == 0) begin
        $display("%0t: beat with no row owed, expected none, got rank %0d score 'h%0h",
                 $time, rank, score);
        mismatches++;
        return;
      end
      want = rows_due.pop_front();
      compare_field("rank", 32'(want.rank), 32'(rank));
      compare_field("score", want.score, score);
      compare_field("accepted", 32'(want.accepted), 32'(accepted));
      compare_field("last", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [31:0]                   in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [tkst_pkg::TDATA_W-1:0]  out_tdata;
  logic                          out_tuser;
  logic                          out_tlast;

  ranking_board board = new();
  bit           calm;       // no idling on either side while set
  bit           hold_req;   // asks the receiver for one long hold-off
  int unsigned  quiet;

  top_k_score_table #(.ENTRIES(N)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Check every output beat taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_row(out_tdata[6:0], out_tdata[38:7], out_tuser, out_tlast);
  end

  // Watchdog: too long with no beat moving on either side
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: random ready, with one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one score; returns just after the rising edge that takes it
  task automatic send_score(input logic signed [31:0] s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    board.take_offer(s);
  endtask

  // Sender pause: drop valid and wait for every owed row
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Random offer, mostly near the current lowest entry so that ties and
  // equal-to-lowest rejects keep happening
  function automatic logic signed [31:0] pick_offer();
    int unsigned sel;
    longint      near;
    sel = $urandom_range(99);
    if (sel < 55) begin
      near = longint'(board.floor_score()) + longint'($urandom_range(6)) - 3;
      if (near > longint'(SCORE_MAX)) near = longint'(SCORE_MAX);
      return near[31:0];
    end
    if (sel < 75)
      return board.entry($urandom_range(N - 1));
    if (sel < 85) begin
      case ($urandom_range(3))
        0:       return SCORE_MAX;
        1:       return SCORE_MIN;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_score(pick_offer());
  endtask

  // Main sequence
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[k]) send_score(OPENING[k]);
    drain();

    send_random(80);

    // stretch with no idling on either side
    calm = 1'b1;
    send_random(50);
    calm = 1'b0;

    // receiver holds off while offers keep coming
    hold_req = 1'b1;
    send_random(12);
    drain();

    send_random(70);
    drain();

    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tkst_pkg.sv
hw/rtl/tkst_cell.sv
hw/rtl/tkst_ctrl.sv
hw/rtl/top_k_score_table.sv
dv/tb_top_k_score_table.sv
